@@ hdl/world_to_screen_projection_assert.svh @@
// ----------------------------------------------------------------------------
// world_to_screen_projection_assert.svh
// assertion macros for the projection block
// ----------------------------------------------------------------------------
`ifndef WORLD_TO_SCREEN_PROJECTION_ASSERT_SVH
`define WORLD_TO_SCREEN_PROJECTION_ASSERT_SVH

`ifndef SYNTHESIS
`define WSP_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("implication check failed");
`define WSP_ASSERT_DLY(lbl, ck, rn, ante, n, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> ##n (cons)) \
        else $error("latency check failed");
`else
`define WSP_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define WSP_ASSERT_DLY(lbl, ck, rn, ante, n, cons)
`endif

`endif

@@ hdl/wsp_pkg.sv @@
// ----------------------------------------------------------------------------
// wsp_pkg
// widths, constants and types shared by the projection pipeline
// ----------------------------------------------------------------------------
package wsp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_W    = 32;
    localparam int HALF_W    = 14;
    // row dot product: three exact products, floored, plus translation
    localparam int DOT_W     = 67 - FRAC_BITS;
    localparam int DEN_W     = DOT_W - 1;
    localparam int MAG_W     = DOT_W;
    localparam int PRD_W     = MAG_W + HALF_W;
    localparam int NUM_W     = PRD_W + FRAC_BITS;
    localparam int CTR_W     = HALF_W + FRAC_BITS;
    // quotient bits kept; the scaled term clamps at 2^40
    localparam int QB        = 41;
    localparam int HI_W      = NUM_W - QB;
    localparam int RES_W     = QB + 3;
    localparam int DEPTH_MIN = ((1 << FRAC_BITS) + 99) / 100;
    // accept edge to strobe sample
    localparam int LATENCY   = QB + 5;

    typedef enum logic [2:0] {
        REG_ROW0_LO,
        REG_ROW0_HI,
        REG_ROW1_LO,
        REG_ROW1_HI,
        REG_ROW2_LO,
        REG_ROW2_HI,
        REG_HALF_WIDTH,
        REG_HALF_HEIGHT
    } wsp_reg_t;

    typedef struct packed {
        logic             vis;
        logic             neg;
        logic [CTR_W-1:0] center;
    } wsp_side_t;

endpackage

@@ hdl/wsp_row_dot.sv @@
// ----------------------------------------------------------------------------
// wsp_row_dot
// two-stage dot product of one matrix row with the world point
// ----------------------------------------------------------------------------
module wsp_row_dot
    import wsp_pkg::*;
(
    input  logic                     clk,
    input  logic [63:0]              lo,
    input  logic [63:0]              hi,
    input  logic signed [WORD_W-1:0] pos_x,
    input  logic signed [WORD_W-1:0] pos_y,
    input  logic signed [WORD_W-1:0] pos_z,
    output logic signed [DOT_W-1:0]  dot
);

    logic signed [63:0]       prod0_reg, prod1_reg, prod2_reg;
    logic signed [63:0]       prod0_next, prod1_next, prod2_next;
    logic [WORD_W-1:0]        trans_reg;
    logic signed [65:0]       sum;
    logic signed [65:0]       sum_sh;
    logic signed [DOT_W-1:0]  dot_reg, dot_next;

    always_comb
    begin
        prod0_next = $signed(lo[31:0])  * pos_x;
        prod1_next = $signed(lo[63:32]) * pos_y;
        prod2_next = $signed(hi[31:0])  * pos_z;
    end

    always_ff @(posedge clk)
    begin
        prod0_reg <= prod0_next;
        prod1_reg <= prod1_next;
        prod2_reg <= prod2_next;
        trans_reg <= hi[63:32];
    end

    // exact sum, floored to the word's fraction bits
    always_comb
    begin
        sum = $signed({{2{prod0_reg[63]}}, prod0_reg})
            + $signed({{2{prod1_reg[63]}}, prod1_reg})
            + $signed({{2{prod2_reg[63]}}, prod2_reg});
        sum_sh = sum >>> FRAC_BITS;
        dot_next = $signed(sum_sh[DOT_W-1:0])
                 + $signed({{(DOT_W-WORD_W){trans_reg[WORD_W-1]}}, trans_reg});
    end

    always_ff @(posedge clk)
    begin
        dot_reg <= dot_next;
    end

    assign dot = dot_reg;

endmodule

@@ hdl/wsp_divider.sv @@
// ----------------------------------------------------------------------------
// wsp_divider
// pipelined restoring divider, clamp, center offset and saturation
// ----------------------------------------------------------------------------
module wsp_divider
    import wsp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [PRD_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  wsp_side_t         side,
    output logic              out_valid,
    output logic              out_vis,
    output logic [WORD_W-1:0] result
);

    logic              vld_reg  [0:QB];
    logic              ovf_reg  [0:QB];
    logic [DEN_W-1:0]  den_reg  [0:QB];
    logic [DEN_W-1:0]  rem_reg  [0:QB];
    logic [QB-1:0]     nq_reg   [0:QB];
    wsp_side_t         side_reg [0:QB];

    logic [NUM_W-1:0]       num_full;
    logic [HI_W-1:0]        num_hi;
    logic                   ovf_next;

    always_comb
    begin
        num_full = {num, {FRAC_BITS{1'b0}}};
        num_hi   = num_full[NUM_W-1:QB];
        // quotient reaches 2^41 or more
        ovf_next = {{DEN_W{1'b0}}, num_hi} >= {{HI_W{1'b0}}, den};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        ovf_reg[0]  <= ovf_next;
        den_reg[0]  <= den;
        rem_reg[0]  <= DEN_W'(num_hi);
        nq_reg[0]   <= num_full[QB-1:0];
        side_reg[0] <= side;
    end

    for (genvar k = 1; k <= QB; k++)
    begin : g_step
        logic [DEN_W:0]   trial;
        logic             ge;
        logic [DEN_W:0]   diff;
        logic [DEN_W-1:0] rem_next;

        always_comb
        begin
            trial    = {rem_reg[k-1], nq_reg[k-1][QB-1]};
            ge       = trial >= {1'b0, den_reg[k-1]};
            diff     = trial - {1'b0, den_reg[k-1]};
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            ovf_reg[k]  <= ovf_reg[k-1];
            den_reg[k]  <= den_reg[k-1];
            rem_reg[k]  <= rem_next;
            nq_reg[k]   <= {nq_reg[k-1][QB-2:0], ge};
            side_reg[k] <= side_reg[k-1];
        end
    end

    localparam logic [QB-1:0] BIG = QB'(1) << (QB - 1);

    logic [QB-1:0]     q;
    logic [RES_W-1:0]  res;
    logic              sat_hi, sat_lo;
    logic [WORD_W-1:0] result_next;
    logic              valid_reg, vis_reg;
    logic [WORD_W-1:0] result_reg;

    always_comb
    begin
        q = (ovf_reg[QB] || (nq_reg[QB] > BIG)) ? BIG : nq_reg[QB];
        if (side_reg[QB].neg)
        begin
            res = RES_W'(side_reg[QB].center) - RES_W'(q);
        end
        else
        begin
            res = RES_W'(side_reg[QB].center) + RES_W'(q);
        end
        sat_hi = !res[RES_W-1] && (|res[RES_W-2:WORD_W-1]);
        sat_lo = res[RES_W-1] && !(&res[RES_W-2:WORD_W-1]);
        if (!side_reg[QB].vis)
        begin
            result_next = '0;
        end
        else if (sat_hi)
        begin
            result_next = {1'b0, {(WORD_W-1){1'b1}}};
        end
        else if (sat_lo)
        begin
            result_next = {1'b1, {(WORD_W-1){1'b0}}};
        end
        else
        begin
            result_next = res[WORD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= vld_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        vis_reg    <= side_reg[QB].vis;
        result_reg <= result_next;
    end

    assign out_valid = valid_reg;
    assign out_vis   = vis_reg;
    assign result    = result_reg;

endmodule

@@ hdl/world_to_screen_projection.sv @@
// ----------------------------------------------------------------------------
// world_to_screen_projection
// perspective projection of a world point to screen pixels, fixed point
// ----------------------------------------------------------------------------
//  channel   signals                           handshake
//  request   pos_x pos_y pos_z                 start, taken when busy is low
//  result    visible screen_x screen_y         strobe, one cycle, no stall
//  config    wr_index wr_data                  wr_en, taken at once
//
//  one request per cycle; busy stays low, the pipeline never stalls
//  pipeline: two row-dot stages, a projection stage, the divider load stage
//  with its overflow check, the 41-step restoring divider (one quotient bit
//  per stage) and the output register
//  reset clears valid bits and configuration; payload registers are not reset
// ----------------------------------------------------------------------------
`include "world_to_screen_projection_assert.svh"

module world_to_screen_projection
    import wsp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [WORD_W-1:0] pos_x,
    input  logic signed [WORD_W-1:0] pos_y,
    input  logic signed [WORD_W-1:0] pos_z,
    output logic                     strobe,
    output logic                     visible,
    output logic signed [WORD_W-1:0] screen_x,
    output logic signed [WORD_W-1:0] screen_y,
    input  logic                     wr_en,
    input  logic [2:0]               wr_index,
    input  logic [63:0]              wr_data
);

    logic [63:0]       row0_lo_reg, row0_hi_reg, row1_lo_reg, row1_hi_reg;
    logic [63:0]       row2_lo_reg, row2_hi_reg;
    logic [HALF_W-1:0] half_width_reg, half_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row0_lo_reg     <= '0;
            row0_hi_reg     <= '0;
            row1_lo_reg     <= '0;
            row1_hi_reg     <= '0;
            row2_lo_reg     <= '0;
            row2_hi_reg     <= '0;
            half_width_reg  <= '0;
            half_height_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (wsp_reg_t'(wr_index))
                REG_ROW0_LO:     row0_lo_reg     <= wr_data;
                REG_ROW0_HI:     row0_hi_reg     <= wr_data;
                REG_ROW1_LO:     row1_lo_reg     <= wr_data;
                REG_ROW1_HI:     row1_hi_reg     <= wr_data;
                REG_ROW2_LO:     row2_lo_reg     <= wr_data;
                REG_ROW2_HI:     row2_hi_reg     <= wr_data;
                REG_HALF_WIDTH:  half_width_reg  <= wr_data[HALF_W-1:0];
                REG_HALF_HEIGHT: half_height_reg <= wr_data[HALF_W-1:0];
                default:         ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic accept;
    logic v1_reg, v2_reg, v3_reg;

    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    logic signed [DOT_W-1:0] dot_x, dot_y, dot_z;

    wsp_row_dot u_dot_x (
        .clk   (clk),
        .lo    (row0_lo_reg),
        .hi    (row0_hi_reg),
        .pos_x (pos_x),
        .pos_y (pos_y),
        .pos_z (pos_z),
        .dot   (dot_x)
    );

    wsp_row_dot u_dot_y (
        .clk   (clk),
        .lo    (row1_lo_reg),
        .hi    (row1_hi_reg),
        .pos_x (pos_x),
        .pos_y (pos_y),
        .pos_z (pos_z),
        .dot   (dot_y)
    );

    wsp_row_dot u_dot_z (
        .clk   (clk),
        .lo    (row2_lo_reg),
        .hi    (row2_hi_reg),
        .pos_x (pos_x),
        .pos_y (pos_y),
        .pos_z (pos_z),
        .dot   (dot_z)
    );

    // projection stage: visibility, magnitudes times half size
    logic [MAG_W-1:0] mag_x, mag_y;
    logic             vis_next;
    logic [PRD_W-1:0] num_x_reg, num_y_reg;
    logic [DEN_W-1:0] den_reg;
    wsp_side_t        side_x_reg, side_y_reg;

    always_comb
    begin
        mag_x    = dot_x[DOT_W-1] ? MAG_W'(-dot_x) : MAG_W'(dot_x);
        mag_y    = dot_y[DOT_W-1] ? MAG_W'(-dot_y) : MAG_W'(dot_y);
        vis_next = !dot_z[DOT_W-1] && (dot_z >= DOT_W'(DEPTH_MIN));
    end

    always_ff @(posedge clk)
    begin
        num_x_reg         <= mag_x * half_width_reg;
        num_y_reg         <= mag_y * half_height_reg;
        den_reg           <= dot_z[DEN_W-1:0];
        side_x_reg.vis    <= vis_next;
        side_x_reg.neg    <= dot_x[DOT_W-1];
        side_x_reg.center <= {half_width_reg, {FRAC_BITS{1'b0}}};
        side_y_reg.vis    <= vis_next;
        // y axis points down on screen
        side_y_reg.neg    <= !dot_y[DOT_W-1];
        side_y_reg.center <= {half_height_reg, {FRAC_BITS{1'b0}}};
    end

    logic              x_valid, x_vis, y_valid, y_vis;
    logic [WORD_W-1:0] x_res, y_res;

    wsp_divider u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .num       (num_x_reg),
        .den       (den_reg),
        .side      (side_x_reg),
        .out_valid (x_valid),
        .out_vis   (x_vis),
        .result    (x_res)
    );

    wsp_divider u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .num       (num_y_reg),
        .den       (den_reg),
        .side      (side_y_reg),
        .out_valid (y_valid),
        .out_vis   (y_vis),
        .result    (y_res)
    );

    assign strobe   = x_valid;
    assign visible  = x_vis;
    assign screen_x = x_res;
    assign screen_y = y_res;

    `WSP_ASSERT_DLY(a_latency, clk, rst_n, accept, LATENCY, strobe)
    `WSP_ASSERT_IMP(a_hidden_zero, clk, rst_n, strobe && !visible, (x_res | y_res) == '0)
    `WSP_ASSERT_IMP(a_no_spurious, clk, rst_n, strobe, $past(accept, LATENCY))
    `WSP_ASSERT_IMP(a_lanes_agree, clk, rst_n, x_valid, y_valid && (y_vis == x_vis))

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// self-checking bench for world_to_screen_projection: points are projected
// by an in-bench fixed-point predictor and each strobed result is compared
// with the oldest expected projection under several matrix/viewport setups
// ----------------------------------------------------------------------------
module tb
    import wsp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } point_t;

    typedef struct {
        logic        vis;
        logic [31:0] sx;
        logic [31:0] sy;
    } projection_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic signed [WORD_W-1:0] pos_x;
    logic signed [WORD_W-1:0] pos_y;
    logic signed [WORD_W-1:0] pos_z;
    logic        strobe;
    logic        visible;
    logic signed [WORD_W-1:0] screen_x;
    logic signed [WORD_W-1:0] screen_y;
    logic        wr_en;
    logic [2:0]  wr_index;
    logic [63:0] wr_data;

    logic [63:0] view_reg [8];
    point_t      point_q [$];
    projection_t projection_expected_q [$];
    point_t      next_pt;
    int          gap_left;
    bit          no_idle;
    int          n_mismatch;

    world_to_screen_projection uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .pos_z    (pos_z),
        .strobe   (strobe),
        .visible  (visible),
        .screen_x (screen_x),
        .screen_y (screen_y),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // exact three-term sum, floored to the fixed-point grid, plus translation
    function automatic logic signed [127:0] row_dot(input logic [63:0] lo, input logic [63:0] hi,
                                                   input point_t p);
        logic signed [127:0] m0, m1, m2, t, cx, cy, cz, acc;
        m0 = $signed(lo[31:0]);
        m1 = $signed(lo[63:32]);
        m2 = $signed(hi[31:0]);
        t  = $signed(hi[63:32]);
        cx = $signed(p.x);
        cy = $signed(p.y);
        cz = $signed(p.z);
        acc = m0 * cx + m1 * cy + m2 * cz;
        acc = acc >>> FRAC_BITS;
        return acc + t;
    endfunction

    function automatic logic [31:0] to_screen(input logic signed [127:0] p, input logic [13:0] h,
                                              input logic signed [127:0] depth, input bit sub);
        logic [127:0]        mag, num, den, q, hx;
        logic signed [127:0] ctr, res;
        bit                  neg;
        mag = (p < 0) ? -p : p;
        hx  = '0;
        hx[13:0] = h;
        num = (mag * hx) << FRAC_BITS;
        den = depth;
        q   = num / den;
        if (q > (128'd1 << 40))
            q = 128'd1 << 40;
        ctr = '0;
        ctr[FRAC_BITS +: 14] = h;
        neg = (p < 0) != sub;
        res = neg ? ctr - $signed(q) : ctr + $signed(q);
        if (res > 128'sh7FFF_FFFF)
            res = 128'sh7FFF_FFFF;
        if (res < -128'sh8000_0000)
            res = -128'sh8000_0000;
        return res[31:0];
    endfunction

    function automatic projection_t predict_projection(input point_t p);
        projection_t         r;
        logic signed [127:0] depth, px, py;
        depth = row_dot(view_reg[REG_ROW2_LO], view_reg[REG_ROW2_HI], p);
        r = '{1'b0, 32'd0, 32'd0};
        if (depth * 100 >= (128'sd1 << FRAC_BITS))
        begin
            px = row_dot(view_reg[REG_ROW0_LO], view_reg[REG_ROW0_HI], p);
            py = row_dot(view_reg[REG_ROW1_LO], view_reg[REG_ROW1_HI], p);
            r.vis = 1'b1;
            r.sx  = to_screen(px, view_reg[REG_HALF_WIDTH][13:0], depth, 1'b0);
            r.sy  = to_screen(py, view_reg[REG_HALF_HEIGHT][13:0], depth, 1'b1);
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            pos_x    <= '0;
            pos_y    <= '0;
            pos_z    <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (start && !busy)
                projection_expected_q.push_back(predict_projection('{pos_x, pos_y, pos_z}));
            if (start && busy)
            begin
                // held until taken
            end
            else if (gap_left != 0)
            begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (point_q.size() != 0)
            begin
                next_pt = point_q.pop_front();
                start    <= 1'b1;
                pos_x    <= next_pt.x;
                pos_y    <= next_pt.y;
                pos_z    <= next_pt.z;
                gap_left <= pick_gap();
            end
            else
                start <= 1'b0;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        projection_t e;
        if (rst_n && strobe)
        begin
            if (projection_expected_q.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result: vis=%0b x=%h y=%h", visible, screen_x, screen_y);
            end
            else
            begin
                e = projection_expected_q.pop_front();
                if (visible !== e.vis || screen_x !== e.sx || screen_y !== e.sy)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("result differs: exp vis=%0b x=%h y=%h, got vis=%0b x=%h y=%h",
                                 e.vis, e.sx, e.sy, visible, screen_x, screen_y);
                end
            end
        end
    end

    task automatic write_reg(input wsp_reg_t idx, input logic [63:0] data);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        if (idx == REG_HALF_WIDTH || idx == REG_HALF_HEIGHT)
            view_reg[idx] = {50'd0, data[13:0]};
        else
            view_reg[idx] = data;
    endtask

    task automatic load_view(input logic [63:0] r0l, input logic [63:0] r0h,
                             input logic [63:0] r1l, input logic [63:0] r1h,
                             input logic [63:0] r2l, input logic [63:0] r2h,
                             input logic [13:0] hw, input logic [13:0] hh);
        logic [63:0] junk;
        write_reg(REG_ROW0_LO, r0l);
        write_reg(REG_ROW0_HI, r0h);
        write_reg(REG_ROW1_LO, r1l);
        write_reg(REG_ROW1_HI, r1h);
        write_reg(REG_ROW2_LO, r2l);
        write_reg(REG_ROW2_HI, r2h);
        // upper bits of the viewport registers are don't-care
        junk = {$urandom, $urandom};
        write_reg(REG_HALF_WIDTH, {junk[63:14], hw});
        junk = {$urandom, $urandom};
        write_reg(REG_HALF_HEIGHT, {junk[63:14], hh});
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    function automatic logic [31:0] small_word();
        return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    endfunction

    // plausible camera: small coefficients, depth row dominated by z
    task automatic load_camera(input logic [13:0] hw, input logic [13:0] hh);
        load_view({small_word(), small_word()}, {small_word(), small_word()},
                  {small_word(), small_word()}, {small_word(), small_word()},
                  {32'h0000_4000 & small_word(), 32'h0000_4000 & small_word()},
                  {32'($urandom_range(0, 32'h0008_0000)),
                   32'($urandom_range(32'h0000_8000, 32'h0002_0000))},
                  hw, hh);
    endtask

    function automatic logic [31:0] rand_coord();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
    endfunction

    task automatic add_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
        point_q.push_back('{x, y, z});
    endtask

    task automatic add_random(input int n);
        repeat (n)
            add_point(rand_coord(), rand_coord(), rand_coord());
    endtask

    task automatic drain();
        @(posedge clk);
        while (point_q.size() != 0 || start || projection_expected_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    initial
    begin
        n_mismatch = 0;
        no_idle    = 1'b0;
        wr_en      = 1'b0;
        wr_index   = '0;
        wr_data    = '0;
        for (int i = 0; i < 8; i++)
            view_reg[i] = '0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // view with a zero x row and unit y and z rows, 1920x1080
        load_view(64'h0, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
                  64'h0, 64'h0000_0000_0001_0000, 14'd960, 14'd540);
        add_point(32'h0, 32'h0, 32'h0);                 // zero depth
        add_point(32'h0, 32'h0, 32'h0001_0000);         // center
        add_point(32'h0, 32'h0, 32'd655);               // just below near limit
        add_point(32'h0, 32'h0, 32'd656);               // just at near limit
        add_point(32'h0001_0000, 32'h0001_0000, 32'd656);
        add_point(32'hFFFF_0000, 32'hFFFF_0000, 32'h0001_0000);
        add_point(32'h0000_8000, 32'hFFFF_8000, 32'h0002_0000);
        add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_point(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        add_point(32'h7FFF_FFFF, 32'h8000_0000, 32'd656);   // saturation on y; x stays at center
        add_point(32'h8000_0000, 32'h7FFF_FFFF, 32'd700);
        add_point(32'h0001_0000, 32'h0001_0000, 32'h8000_0000); // behind camera
        add_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_point(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_1234);
        add_point(32'h1234_5678, 32'h8765_4321, 32'h0100_0000);
        drain();

        no_idle = 1'b1;
        load_camera(14'd960, 14'd540);
        add_random(150);
        drain();

        no_idle = 1'b0;
        load_camera(14'h3FFF, 14'h3FFF);
        add_random(150);
        drain();

        load_camera(14'd0, 14'd0);
        add_random(150);
        drain();

        load_view({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                  14'($urandom), 14'($urandom));
        add_random(150);
        drain();

        load_view('1, '1, '1, '1, '1, '1, 14'd8192, 14'd8192);
        add_random(150);
        drain();

        load_camera(14'($urandom_range(0, 16383)), 14'($urandom_range(0, 16383)));
        add_random(150);
        drain();

        load_camera(14'd1, 14'd8192);
        add_random(150);
        drain();

        if (n_mismatch == 0)
            $display("world_to_screen_projection: match");
        else
            $display("world_to_screen_projection: mismatch");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("world_to_screen_projection: mismatch");
        $finish;
    end

endmodule

@@ world_to_screen_projection.f @@
+incdir+hdl
hdl/wsp_pkg.sv
hdl/wsp_row_dot.sv
hdl/wsp_divider.sv
hdl/world_to_screen_projection.sv
dv/tb.sv
